@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the RTL. They expand to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge outside reset.
`define NPC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication checked at every clock edge outside reset.
`define NPC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define NPC_ASSERT(lbl, clk, rst_n, prop, msg)

`define NPC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/npc_pkg.sv @@
// ----------------------------------------------------------------------------
// npc_pkg
// Types, codes and constants shared by the nearest palette color unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package npc_pkg;

    // Default number of palette entries.
    localparam int PALETTE_DEPTH_DEF = 16;

    // Channel, distance and configuration widths.
    localparam int CH_W       = 8;
    localparam int TERM_W     = 16;
    localparam int DIST_W     = 18;
    localparam int IDX_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int SLOPE_W    = 16;
    localparam int SIZE_W     = 5;

    // Item commands.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_MAP   = 1'b1;

    // Distance modes; the unused code behaves as Euclidean.
    typedef enum logic [1:0] {
        MODE_EUCLID    = 2'd0,
        MODE_MANHATTAN = 2'd1,
        MODE_REMAP     = 2'd2
    } t_mode;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAPPING_MODE   = 3'd0,
        CFG_PALETTE_SIZE   = 3'd1,
        CFG_INPUT_MINIMUM  = 3'd2,
        CFG_OUTPUT_MINIMUM = 3'd3,
        CFG_SLOPE_RED      = 3'd4,
        CFG_SLOPE_GREEN    = 3'd5,
        CFG_SLOPE_BLUE     = 3'd6
    } t_cfg_idx;

    // Packed RGB color, red in the upper byte.
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    // Input item.
    typedef struct packed {
        logic             cmd;
        logic [IDX_W-1:0] entry_index;
        logic [CH_W-1:0]  pixel_red;
        logic [CH_W-1:0]  pixel_green;
        logic [CH_W-1:0]  pixel_blue;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic [IDX_W-1:0] nearest_index;
        logic [CH_W-1:0]  nearest_red;
        logic [CH_W-1:0]  nearest_green;
        logic [CH_W-1:0]  nearest_blue;
    } t_out_item;

endpackage

@@ rtl/npc_remap_chan.sv @@
// ----------------------------------------------------------------------------
// npc_remap_chan
// Two-stage linear remap of one color channel: Q8.8 slope times offset pixel,
// plus the output minimum, truncated and clamped to 0..255.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module npc_remap_chan (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic                          i_remap,
    input  logic [npc_pkg::CH_W-1:0]      i_pixel,
    input  logic [npc_pkg::CH_W-1:0]      i_in_min,
    input  logic [npc_pkg::CH_W-1:0]      i_out_min,
    input  logic [npc_pkg::SLOPE_W-1:0]   i_slope,
    output logic [npc_pkg::CH_W-1:0]      o_color
);

    localparam int PROD_W = npc_pkg::SLOPE_W + npc_pkg::CH_W + 2;
    localparam int SUM_W  = PROD_W + 1;

    logic signed [npc_pkg::CH_W:0]   n_diff;
    logic signed [PROD_W-1:0]        n_prod;
    logic signed [PROD_W-1:0]        r_prod;
    logic [npc_pkg::CH_W-1:0]        r_pix;
    logic                            r_remap;
    logic [SUM_W-1:0]                n_sum;
    logic [SUM_W-9:0]                n_int;
    logic [npc_pkg::CH_W-1:0]        n_color;
    logic [npc_pkg::CH_W-1:0]        r_color;

    // Stage one: offset the pixel and scale it by the slope.
    assign n_diff = $signed({1'b0, i_pixel}) - $signed({1'b0, i_in_min});
    assign n_prod = PROD_W'($signed({1'b0, i_slope})) * PROD_W'(n_diff);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= n_prod;
            r_pix   <= i_pixel;
            r_remap <= i_remap;
        end
    end

    // Stage two: add the output minimum in Q8.8, then truncate and clamp.
    assign n_sum = {{(SUM_W-npc_pkg::CH_W-8){1'b0}}, i_out_min, 8'h00}
                 + {r_prod[PROD_W-1], r_prod};
    assign n_int = n_sum[SUM_W-1:8];

    always_comb begin
        if (!r_remap) begin
            n_color = r_pix;
        end else if (n_sum[SUM_W-1]) begin
            n_color = '0;
        end else if (|n_int[SUM_W-9:npc_pkg::CH_W]) begin
            n_color = '1;
        end else begin
            n_color = n_int[npc_pkg::CH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_color <= n_color;
        end
    end

    assign o_color = r_color;

endmodule

@@ rtl/nearest_palette_color_unit.sv @@
// ----------------------------------------------------------------------------
// nearest_palette_color_unit
// Maps pixels to the nearest entry of a programmable RGB palette.
//
// Write items load one palette entry; map items return the index and color
// of the closest entry under squared Euclidean or Manhattan distance,
// optionally after a per-channel linear remap, ties going to the lowest
// index. The unit accepts one item per clock cycle while the result side
// does not stall, and returns each map result through the input and remap
// stages, the stages that form the per-entry distances and the registered
// minimum tree across the palette. A stall on the result side freezes the
// whole pipeline. Palette writes take effect in item order relative to map
// items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nearest_palette_color_unit #(
    parameter int PALETTE_DEPTH = npc_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Item input
    input  logic                              i_valid,
    output logic                              o_stall,
    input  npc_pkg::t_in_item                 i_data,
    // Result output
    output logic                              o_valid,
    input  logic                              i_stall,
    output npc_pkg::t_out_item                o_data,
    // Configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [npc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [npc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int LVLS   = $clog2(PALETTE_DEPTH);
    localparam int LEAVES = 2 ** LVLS;

    // One node of the minimum tree.
    typedef struct packed {
        logic                       ok;
        logic [npc_pkg::DIST_W-1:0] metric;
        logic [LVLS-1:0]            idx;
        npc_pkg::t_rgb              col;
    } t_node;

    // Keep the left node unless it is not valid or the right one is valid and strictly closer.
    function automatic t_node pick(input t_node a, input t_node b);
        t_node res;
        if (a.ok && (!b.ok || (a.metric <= b.metric))) begin
            res = a;
        end else begin
            res = b;
        end
        return res;
    endfunction

    // Configuration registers.
    npc_pkg::t_mode                  r_cfg_mode;
    logic [npc_pkg::SIZE_W-1:0]      r_cfg_size;
    npc_pkg::t_rgb                   r_cfg_in_min;
    npc_pkg::t_rgb                   r_cfg_out_min;
    logic [npc_pkg::SLOPE_W-1:0]     r_cfg_slope_r;
    logic [npc_pkg::SLOPE_W-1:0]     r_cfg_slope_g;
    logic [npc_pkg::SLOPE_W-1:0]     r_cfg_slope_b;

    // Pipeline control and stage registers.
    logic                            adv;
    logic                            r_s1_vld;
    npc_pkg::t_in_item               r_s1;
    logic                            r_s2_vld;
    logic                            r_s2_cmd;
    logic [npc_pkg::IDX_W-1:0]       r_s2_idx;
    logic                            r_s3_vld;
    logic                            r_s3_cmd;
    logic [npc_pkg::IDX_W-1:0]       r_s3_idx;
    npc_pkg::t_rgb                   s3_col;
    logic                            s1_remap;
    logic                            manhattan;
    logic                            pal_wr;
    logic [LVLS+1:0]                 r_mv;

    // Palette and search registers.
    npc_pkg::t_rgb                   r_palette [PALETTE_DEPTH];
    logic [npc_pkg::TERM_W-1:0]      r_term_r  [PALETTE_DEPTH];
    logic [npc_pkg::TERM_W-1:0]      r_term_g  [PALETTE_DEPTH];
    logic [npc_pkg::TERM_W-1:0]      r_term_b  [PALETTE_DEPTH];
    npc_pkg::t_rgb                   r_lcol    [PALETTE_DEPTH];
    logic                            r_lok     [PALETTE_DEPTH];
    t_node                           r_node    [1:2*LEAVES-1];

    // The pipeline moves unless a finished result is held by the receiver.
    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    // Configuration port; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mode    <= npc_pkg::MODE_EUCLID;
            r_cfg_size    <= npc_pkg::SIZE_W'(1);
            r_cfg_in_min  <= '0;
            r_cfg_out_min <= '0;
            r_cfg_slope_r <= npc_pkg::SLOPE_W'(256);
            r_cfg_slope_g <= npc_pkg::SLOPE_W'(256);
            r_cfg_slope_b <= npc_pkg::SLOPE_W'(256);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (npc_pkg::t_cfg_idx'(i_cfg_index))
                npc_pkg::CFG_MAPPING_MODE: begin
                    r_cfg_mode <= npc_pkg::t_mode'(i_cfg_data[1:0]);
                end
                npc_pkg::CFG_PALETTE_SIZE: begin
                    r_cfg_size <= i_cfg_data[npc_pkg::SIZE_W-1:0];
                end
                npc_pkg::CFG_INPUT_MINIMUM: begin
                    r_cfg_in_min <= i_cfg_data;
                end
                npc_pkg::CFG_OUTPUT_MINIMUM: begin
                    r_cfg_out_min <= i_cfg_data;
                end
                npc_pkg::CFG_SLOPE_RED: begin
                    r_cfg_slope_r <= i_cfg_data[npc_pkg::SLOPE_W-1:0];
                end
                npc_pkg::CFG_SLOPE_GREEN: begin
                    r_cfg_slope_g <= i_cfg_data[npc_pkg::SLOPE_W-1:0];
                end
                npc_pkg::CFG_SLOPE_BLUE: begin
                    r_cfg_slope_b <= i_cfg_data[npc_pkg::SLOPE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign manhattan = (r_cfg_mode == npc_pkg::MODE_MANHATTAN);
    assign s1_remap  = (r_s1.cmd == npc_pkg::CMD_MAP) && (r_cfg_mode == npc_pkg::MODE_REMAP);

    // Valid bits of the input and remap stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else if (adv) begin
            r_s1_vld <= i_valid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    // Item payload of the input and remap stages.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1     <= i_data;
            r_s2_cmd <= r_s1.cmd;
            r_s2_idx <= r_s1.entry_index;
            r_s3_cmd <= r_s2_cmd;
            r_s3_idx <= r_s2_idx;
        end
    end

    // Per-channel remap, two stages; writes pass their color unchanged.
    npc_remap_chan u_remap_r (
        .i_clk     (i_clk),
        .i_en      (adv),
        .i_remap   (s1_remap),
        .i_pixel   (r_s1.pixel_red),
        .i_in_min  (r_cfg_in_min.red),
        .i_out_min (r_cfg_out_min.red),
        .i_slope   (r_cfg_slope_r),
        .o_color   (s3_col.red)
    );

    npc_remap_chan u_remap_g (
        .i_clk     (i_clk),
        .i_en      (adv),
        .i_remap   (s1_remap),
        .i_pixel   (r_s1.pixel_green),
        .i_in_min  (r_cfg_in_min.green),
        .i_out_min (r_cfg_out_min.green),
        .i_slope   (r_cfg_slope_g),
        .o_color   (s3_col.green)
    );

    npc_remap_chan u_remap_b (
        .i_clk     (i_clk),
        .i_en      (adv),
        .i_remap   (s1_remap),
        .i_pixel   (r_s1.pixel_blue),
        .i_in_min  (r_cfg_in_min.blue),
        .i_out_min (r_cfg_out_min.blue),
        .i_slope   (r_cfg_slope_b),
        .o_color   (s3_col.blue)
    );

    // Palette write as the item leaves stage three, so that it orders with maps.
    assign pal_wr = adv && r_s3_vld && (r_s3_cmd == npc_pkg::CMD_WRITE)
                 && (32'(r_s3_idx) < PALETTE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (pal_wr) begin
            r_palette[LVLS'(r_s3_idx)] <= s3_col;
        end
    end

    // Map-item valid bits through the distance stages and the tree levels.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= '0;
        end else if (adv) begin
            r_mv <= {r_mv[LVLS:0], r_s3_vld && (r_s3_cmd == npc_pkg::CMD_MAP)};
        end
    end

    // Distance terms per entry, then their sum as a tree leaf.
    for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
        if (i < PALETTE_DEPTH) begin : g_used
            logic [npc_pkg::CH_W-1:0] d_r;
            logic [npc_pkg::CH_W-1:0] d_g;
            logic [npc_pkg::CH_W-1:0] d_b;

            assign d_r = (s3_col.red > r_palette[i].red)
                       ? s3_col.red - r_palette[i].red : r_palette[i].red - s3_col.red;
            assign d_g = (s3_col.green > r_palette[i].green)
                       ? s3_col.green - r_palette[i].green
                       : r_palette[i].green - s3_col.green;
            assign d_b = (s3_col.blue > r_palette[i].blue)
                       ? s3_col.blue - r_palette[i].blue : r_palette[i].blue - s3_col.blue;

            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_term_r[i] <= manhattan ? npc_pkg::TERM_W'(d_r)
                                 : npc_pkg::TERM_W'(d_r) * npc_pkg::TERM_W'(d_r);
                    r_term_g[i] <= manhattan ? npc_pkg::TERM_W'(d_g)
                                 : npc_pkg::TERM_W'(d_g) * npc_pkg::TERM_W'(d_g);
                    r_term_b[i] <= manhattan ? npc_pkg::TERM_W'(d_b)
                                 : npc_pkg::TERM_W'(d_b) * npc_pkg::TERM_W'(d_b);
                    r_lcol[i]   <= r_palette[i];
                    r_lok[i]    <= (i == 0) || (9'(i) < 9'(r_cfg_size));
                end
            end

            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_node[LEAVES+i].ok     <= r_lok[i];
                    r_node[LEAVES+i].metric <= npc_pkg::DIST_W'(r_term_r[i])
                                             + npc_pkg::DIST_W'(r_term_g[i])
                                             + npc_pkg::DIST_W'(r_term_b[i]);
                    r_node[LEAVES+i].idx    <= LVLS'(i);
                    r_node[LEAVES+i].col    <= r_lcol[i];
                end
            end
        end else begin : g_pad
            // Leaves past the palette never win.
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_node[LEAVES+i] <= '0;
                end
            end
        end
    end

    // Registered minimum tree, each level registered; node 1 is the result.
    for (genvar n = 1; n < LEAVES; n++) begin : g_tree
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_node[n] <= pick(r_node[2*n], r_node[2*n+1]);
            end
        end
    end

    // Result transfer.
    assign o_valid                = r_mv[LVLS+1];
    assign o_data.nearest_index   = npc_pkg::IDX_W'(r_node[1].idx);
    assign o_data.nearest_red     = r_node[1].col.red;
    assign o_data.nearest_green   = r_node[1].col.green;
    assign o_data.nearest_blue    = r_node[1].col.blue;

    // A held result must stall the input side.
    `NPC_ASSERT_IMPL(a_hold_stalls, i_clk, i_rst_n, o_valid && i_stall, o_stall,
        "result held but input not stalled")

    // Every result comes from a searched entry.
    `NPC_ASSERT_IMPL(a_result_ok, i_clk, i_rst_n, o_valid, r_node[1].ok,
        "result taken from an entry outside the palette size")

    // A new result appears only when the pipeline advanced.
    `NPC_ASSERT_IMPL(a_rise_on_adv, i_clk, i_rst_n, $rose(o_valid), $past(adv),
        "result appeared while the pipeline was frozen")

endmodule
